FILE: hdl/mau_pkg.sv
// Shared constants, operation codes and status codes of the modular arithmetic unit.
package mau_pkg;

  localparam int RESIDUE_W        = 31;
  localparam int STATUS_W         = 2;
  localparam int FUNC_W           = 3;
  localparam int OPND_W           = 64;
  localparam int DEF_RESIDUE_BITS = 31;
  localparam int IN_TDATA_W       = 136;
  localparam int OUT_TDATA_W      = 40;

  localparam logic [RESIDUE_W-1:0] MOD_RESET = 31'd1000000007;

  localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DIV = 3'd3;
  localparam logic [FUNC_W-1:0] FN_POW = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NEG_EXP = 2'd2;

endpackage

FILE: hdl/mau_step.sv
// One bit step of the shared remainder unit: r' = (2r + add) mod d, with quotient bit.
module mau_step #(
  parameter int W = mau_pkg::DEF_RESIDUE_BITS
) (
  input  logic [W-1:0] r,
  input  logic [W-1:0] add,
  input  logic [W-1:0] d,
  output logic [W-1:0] r_out,
  output logic         q
);

  logic [W+1:0] t;
  logic [W+1:0] d1;
  logic [W+1:0] d2;
  logic [W+1:0] res;

  // With r and add below d the sum stays below three times d.
  assign t  = {1'b0, r, 1'b0} + {2'b00, add};
  assign d1 = {2'b00, d};
  assign d2 = {1'b0, d, 1'b0};

  always_comb begin
    if (t >= d2) begin
      res = t - d2;
    end else if (t >= d1) begin
      res = t - d1;
    end else begin
      res = t;
    end
  end

  assign r_out = res[W-1:0];
  assign q     = (t >= d1);

endmodule

FILE: hdl/modular_arithmetic_unit.sv
// Modular arithmetic unit: add, subtract, multiply, divide and power modulo a configured modulus.
//
// One item is worked on at a time through a single bit-serial remainder unit. Each operand
// is first reduced, a and then b; add, subtract and reduce then finish in the dispatch step.
// A modular multiply is a bit-serial pass over W = min(RESIDUE_BITS, 31) bits. Divide runs
// the extended Euclid loop, one remainder pass per quotient step, then one multiply. Power
// squares for all 63 exponent bits and multiplies for each set bit. The next item is taken
// once the result has moved to the output register; a waiting result does not block the
// following item's work.
module modular_arithmetic_unit #(
  parameter int RESIDUE_BITS = mau_pkg::DEF_RESIDUE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mau_pkg::RESIDUE_W-1:0]    cfg_data,    // modulus
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mau_pkg::IN_TDATA_W-1:0]   in_tdata,    // func[2:0], operand_a[66:3], operand_b[130:67]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mau_pkg::OUT_TDATA_W-1:0]  out_tdata    // residue[30:0], status[32:31]
);
  import mau_pkg::*;

  localparam int MW    = (RESIDUE_BITS < RESIDUE_W) ? RESIDUE_BITS : RESIDUE_W;
  localparam int EW    = MW + 2;
  localparam int CNT_W = $clog2(OPND_W + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RED  = 7'b0000010,
    S_DISP = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_EDIV = 7'b0010000,
    S_EUPD = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [MW-1:0]          m_r;
  logic [FUNC_W-1:0]      func_r, func_nxt;
  logic [OPND_W-1:0]      rb_r, rb_nxt;
  logic [MW-1:0]          a_r, a_nxt, b_r, b_nxt, x_r, x_nxt, r_r, r_nxt, q_r, q_nxt;
  logic [MW-1:0]          en_r, en_nxt, res_r, res_nxt;
  logic [OPND_W-1:0]      sh_r, sh_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt, red_b_r, red_b_nxt, mulb_r, mulb_nxt;
  logic [5:0]             idx_r, idx_nxt;
  logic signed [EW-1:0]   eu_r, eu_nxt, ev_r, ev_nxt;
  logic [STATUS_W-1:0]    sts_r, sts_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [MW-1:0]          step_add, step_d, step_r;
  logic                   step_q;
  logic [OPND_W-1:0]      in_a, in_b;
  logic [MW-1:0]          red_val, coef;
  logic [MW:0]            sum, dif;
  logic signed [EW-1:0]   prod, mext, cfix;
  logic                   load_out;

  assign in_a = in_tdata[FUNC_W +: OPND_W];
  assign in_b = in_tdata[FUNC_W+OPND_W +: OPND_W];

  assign step_add = (st_r == S_MUL) ? (sh_r[OPND_W-1] ? x_r : '0) : MW'(sh_r[OPND_W-1]);
  assign step_d   = (st_r == S_EDIV) ? en_r : m_r;

  mau_step #(.W(MW)) u_step (
    .r     (r_r),
    .add   (step_add),
    .d     (step_d),
    .r_out (step_r),
    .q     (step_q)
  );

  assign red_val = (neg_r && (step_r != '0)) ? (m_r - step_r) : step_r;
  assign sum     = {1'b0, a_r} + {1'b0, b_r};
  assign dif     = (a_r >= b_r) ? ({1'b0, a_r} - {1'b0, b_r})
                                : ({1'b0, a_r} + {1'b0, m_r} - {1'b0, b_r});
  assign prod    = $signed({2'b00, q_r}) * ev_r;
  assign mext    = $signed({2'b00, m_r});
  assign cfix    = (ev_r < 0) ? (ev_r + mext) : ((ev_r >= mext) ? (ev_r - mext) : ev_r);
  assign coef    = cfix[MW-1:0];

  always_comb begin
    st_nxt    = st_r;
    func_nxt  = func_r;
    rb_nxt    = rb_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    x_nxt     = x_r;
    r_nxt     = r_r;
    q_nxt     = q_r;
    en_nxt    = en_r;
    res_nxt   = res_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    red_b_nxt = red_b_r;
    mulb_nxt  = mulb_r;
    idx_nxt   = idx_r;
    eu_nxt    = eu_r;
    ev_nxt    = ev_r;
    sts_nxt   = sts_r;
    load_out  = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tdata[FUNC_W-1:0];
          rb_nxt    = in_b;
          neg_nxt   = in_a[OPND_W-1];
          sh_nxt    = in_a[OPND_W-1] ? (~in_a + 1'b1) : in_a;
          r_nxt     = '0;
          cnt_nxt   = CNT_W'(OPND_W);
          red_b_nxt = 1'b0;
          st_nxt    = S_RED;
        end
      end
      S_RED: begin
        r_nxt   = step_r;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          if (!red_b_r) begin
            a_nxt     = red_val;
            neg_nxt   = rb_r[OPND_W-1];
            sh_nxt    = rb_r[OPND_W-1] ? (~rb_r + 1'b1) : rb_r;
            r_nxt     = '0;
            cnt_nxt   = CNT_W'(OPND_W);
            red_b_nxt = 1'b1;
          end else begin
            b_nxt  = red_val;
            st_nxt = S_DISP;
          end
        end
      end
      S_DISP: begin
        sts_nxt = ST_OK;
        res_nxt = '0;
        st_nxt  = S_FIN;
        if (m_r >= MW'(2)) begin
          case (func_r)
            FN_ADD: begin
              res_nxt = (sum >= {1'b0, m_r}) ? MW'(sum - {1'b0, m_r}) : sum[MW-1:0];
            end
            FN_SUB: begin
              res_nxt = dif[MW-1:0];
            end
            FN_MUL: begin
              x_nxt   = a_r;
              sh_nxt  = {b_r, (OPND_W-MW)'(0)};
              r_nxt   = '0;
              cnt_nxt = CNT_W'(MW);
              st_nxt  = S_MUL;
            end
            FN_DIV: begin
              if (b_r == '0) begin
                sts_nxt = ST_DIV_ZERO;
              end else begin
                en_nxt  = m_r;
                eu_nxt  = EW'(1);
                ev_nxt  = '0;
                sh_nxt  = {b_r, (OPND_W-MW)'(0)};
                r_nxt   = '0;
                q_nxt   = '0;
                cnt_nxt = CNT_W'(MW);
                st_nxt  = S_EDIV;
              end
            end
            FN_POW: begin
              if (rb_r[OPND_W-1]) begin
                sts_nxt = ST_NEG_EXP;
              end else if (rb_r == '0) begin
                res_nxt = MW'(1);
              end else if (a_r != '0) begin
                // Square and multiply from exponent bit 62 down, starting from one.
                idx_nxt  = 6'd62;
                mulb_nxt = 1'b0;
                x_nxt    = MW'(1);
                sh_nxt   = {MW'(1), (OPND_W-MW)'(0)};
                r_nxt    = '0;
                cnt_nxt  = CNT_W'(MW);
                st_nxt   = S_MUL;
              end
            end
            default: begin
              res_nxt = a_r;
            end
          endcase
        end
      end
      S_MUL: begin
        r_nxt   = step_r;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          if (func_r != FN_POW) begin
            res_nxt = step_r;
            st_nxt  = S_FIN;
          end else if (!mulb_r && rb_r[idx_r]) begin
            x_nxt    = a_r;
            sh_nxt   = {step_r, (OPND_W-MW)'(0)};
            r_nxt    = '0;
            cnt_nxt  = CNT_W'(MW);
            mulb_nxt = 1'b1;
          end else if (idx_r == '0) begin
            res_nxt = step_r;
            st_nxt  = S_FIN;
          end else begin
            idx_nxt  = idx_r - 1'b1;
            x_nxt    = step_r;
            sh_nxt   = {step_r, (OPND_W-MW)'(0)};
            r_nxt    = '0;
            cnt_nxt  = CNT_W'(MW);
            mulb_nxt = 1'b0;
          end
        end
      end
      S_EDIV: begin
        r_nxt   = step_r;
        sh_nxt  = sh_r << 1;
        q_nxt   = {q_r[MW-2:0], step_q};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          st_nxt = S_EUPD;
        end
      end
      S_EUPD: begin
        // The coefficients stay within the modulus, so the truncated product is exact.
        eu_nxt = ev_r;
        ev_nxt = eu_r - prod;
        en_nxt = r_r;
        r_nxt  = '0;
        if (r_r == '0) begin
          x_nxt   = a_r;
          sh_nxt  = {coef, (OPND_W-MW)'(0)};
          cnt_nxt = CNT_W'(MW);
          st_nxt  = S_MUL;
        end else begin
          sh_nxt  = {en_r, (OPND_W-MW)'(0)};
          q_nxt   = '0;
          cnt_nxt = CNT_W'(MW);
          st_nxt  = S_EDIV;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          load_out = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out | (out_valid_r & ~out_tready);
  assign out_data_nxt  = load_out ? OUT_TDATA_W'({sts_r, RESIDUE_W'(res_r)}) : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      m_r         <= MOD_RESET[MW-1:0];
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        m_r <= cfg_data[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    rb_r       <= rb_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    x_r        <= x_nxt;
    r_r        <= r_nxt;
    q_r        <= q_nxt;
    en_r       <= en_nxt;
    res_r      <= res_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    red_b_r    <= red_b_nxt;
    mulb_r     <= mulb_nxt;
    idx_r      <= idx_nxt;
    eu_r       <= eu_nxt;
    ev_r       <= ev_nxt;
    sts_r      <= sts_nxt;
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hdl/mau_checker.sv
// Port-level checks on the modular arithmetic unit, bound to the top level.
module mau_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mau_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mau_pkg::*;

  // A held result must not change while the far side stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The unit works on one item at a time, so it is busy right after a transfer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:31] == ST_OK) || (out_tdata[32:31] == ST_DIV_ZERO) ||
                   (out_tdata[32:31] == ST_NEG_EXP))
    else $error("undefined status code");

  // Any error status carries a zero residue.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[32:31] != ST_OK) |-> out_tdata[30:0] == '0)
    else $error("error result with non-zero residue");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
